### src/pee_pkg.sv
// Shared types, character codes and status codes of the postfix evaluator.
// No dependencies; imported by pee_ctrl, pee_dpath and the top level.
package pee_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_W         = 32;

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_ILLEGAL = 3'd1,
		STAT_UNDER   = 3'd2,
		STAT_OVER    = 3'd3,
		STAT_DIVZERO = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL,
		ST_DIV,
		ST_DIVWB,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    push;       // digit: spill TOS, load digit, count+1
		logic    pop;        // operator: read next-of-stack, count-1
		logic    clear;      // empty the stack
		op_t     op;
		logic    exec;       // first execute cycle, next-of-stack on RAM output
		logic    mul_wb;
		logic    div_step;
		logic    div_wb;
		logic    out_load;
		status_t out_status;
		logic    out_zero;   // result value 0 instead of TOS
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
		logic cnt_lt2;
		logic cnt_full;
		logic tos_zero;
		logic div_last;
	} dp_stat_t;

endpackage

### src/pee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/pee_ctrl.sv
// Controller FSM: classifies symbols, sequences operators, owns the output valid.
// Depends on pee_pkg.
module pee_ctrl
	import pee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic [7:0] symbol,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		SC_SKIP,
		SC_DIGIT,
		SC_END,
		SC_OP,
		SC_ILLEGAL
	} sym_class_t;

	state_t     state_q, state_d;
	op_t        op_q, sym_op;
	sym_class_t sym_class;
	status_t    pend_st_q, pend_st_d;
	logic       pend_zero_q, pend_zero_d, pend_load;
	logic       out_valid_q;
	logic       accept, slot_free;

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;

	always_comb begin
		sym_op = OP_ADD;
		unique case (symbol) inside
			CH_SPACE, CH_TAB, CH_COMMA: sym_class = SC_SKIP;
			[CH_ZERO:CH_NINE]:          sym_class = SC_DIGIT;
			CH_END:                     sym_class = SC_END;
			CH_PLUS:  begin sym_class = SC_OP; sym_op = OP_ADD; end
			CH_MINUS: begin sym_class = SC_OP; sym_op = OP_SUB; end
			CH_STAR:  begin sym_class = SC_OP; sym_op = OP_MUL; end
			CH_SLASH: begin sym_class = SC_OP; sym_op = OP_DIV; end
			default:                    sym_class = SC_ILLEGAL;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (sym_class)
						SC_SKIP:    state_d = ST_IDLE;
						SC_DIGIT:   state_d = stat.cnt_full ? ST_EMIT : ST_IDLE;
						SC_OP:      state_d = stat.cnt_lt2 ? ST_EMIT : ST_FETCH;
						default:    state_d = ST_EMIT;
					endcase
				end
			end
			ST_FETCH: begin
				unique case (op_q)
					OP_MUL:  state_d = ST_MUL;
					OP_DIV:  state_d = stat.tos_zero ? ST_EMIT : ST_DIV;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_MUL:   state_d = ST_IDLE;
			ST_DIV:   state_d = stat.div_last ? ST_DIVWB : ST_DIV;
			ST_DIVWB: state_d = ST_IDLE;
			ST_EMIT:  state_d = slot_free ? ST_IDLE : ST_EMIT;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd            = '0;
		cmd.op         = op_q;
		cmd.out_status = pend_st_q;
		cmd.out_zero   = pend_zero_q;
		s_tready       = 1'b0;
		pend_load      = 1'b0;
		pend_st_d      = STAT_OK;
		pend_zero_d    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					unique case (sym_class)
						SC_SKIP: ;
						SC_DIGIT: begin
							if (stat.cnt_full) begin
								cmd.clear = 1'b1;
								pend_load = 1'b1;
								pend_st_d = STAT_OVER;
							end else begin
								cmd.push = 1'b1;
							end
						end
						SC_END: begin
							cmd.clear   = 1'b1;
							pend_load   = 1'b1;
							pend_st_d   = stat.cnt_zero ? STAT_UNDER : STAT_OK;
							pend_zero_d = stat.cnt_zero;
						end
						SC_OP: begin
							if (stat.cnt_lt2) begin
								cmd.clear = 1'b1;
								pend_load = 1'b1;
								pend_st_d = STAT_UNDER;
							end else begin
								cmd.pop = 1'b1;
							end
						end
						default: begin
							cmd.clear = 1'b1;
							pend_load = 1'b1;
							pend_st_d = STAT_ILLEGAL;
						end
					endcase
				end
			end
			ST_FETCH: begin
				cmd.exec = 1'b1;
				if (op_q == OP_DIV && stat.tos_zero) begin
					pend_load   = 1'b1;
					pend_st_d   = STAT_DIVZERO;
					pend_zero_d = 1'b0;
				end
			end
			ST_MUL:   cmd.mul_wb = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_DIVWB: cmd.div_wb = 1'b1;
			ST_EMIT:  cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ADD;
			pend_st_q   <= STAT_OK;
			pend_zero_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= sym_op;
			end
			if (pend_load) begin
				pend_st_q   <= pend_st_d;
				pend_zero_q <= pend_zero_d;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/pee_dpath.sv
// Datapath: TOS register, stack RAM below it, add/sub, multiplier,
// bit-serial divider and the result register. Depends on pee_pkg, pee_ram.
module pee_dpath
	import pee_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         symbol,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic [VALUE_W-1:0] value,
	output status_t            status
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int QW     = VALUE_W + FRAC_BITS;   // quotient bits
	localparam int DCNT_W = $clog2(QW);

	localparam logic [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

	function automatic logic [VALUE_W-1:0] mag(input logic [VALUE_W-1:0] v);
		mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
	endfunction

	// sign a magnitude, saturate to 32 bits
	function automatic logic [VALUE_W-1:0] sat_mag(input logic [63:0] m, input logic neg);
		if (neg) begin
			sat_mag = (m >= 64'(VMIN)) ? VMIN : (~m[VALUE_W-1:0] + 1'b1);
		end else begin
			sat_mag = (m > 64'(VMAX)) ? VMAX : m[VALUE_W-1:0];
		end
	endfunction

	logic [CNT_W-1:0]   count_q, cnt_m1, cnt_m2;
	logic [VALUE_W-1:0] tos_q, nos;
	logic [VALUE_W-1:0] digit_val, addsub_res, dz_val;
	logic [VALUE_W:0]   a_ext, b_ext, sum;
	logic [63:0]        prod_q;
	logic               neg_q;
	logic [QW-1:0]      quo_q;
	logic [VALUE_W-1:0] rem_q, dvs_q;
	logic [VALUE_W:0]   rem_sh;
	logic               ge;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [VALUE_W-1:0] value_q;
	status_t            status_q;

	assign cnt_m1 = count_q - 1'b1;
	assign cnt_m2 = count_q - CNT_W'(2);

	pee_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push && count_q != '0),
		.waddr(cnt_m1[ADDR_W-1:0]),
		.wdata(tos_q),
		.raddr(cnt_m2[ADDR_W-1:0]),
		.rdata(nos)
	);

	assign stat.cnt_zero = (count_q == '0);
	assign stat.cnt_lt2  = (count_q < CNT_W'(2));
	assign stat.cnt_full = (count_q == CNT_W'(STACK_DEPTH));
	assign stat.tos_zero = (tos_q == '0);
	assign stat.div_last = (div_cnt_q == DCNT_W'(QW - 1));

	assign digit_val = VALUE_W'(symbol[3:0]) << FRAC_BITS;

	// left operand = nos, right operand = tos
	assign a_ext = {nos[VALUE_W-1], nos};
	assign b_ext = {tos_q[VALUE_W-1], tos_q};
	assign sum   = (cmd.op == OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
	always_comb begin
		if (sum[VALUE_W] != sum[VALUE_W-1]) begin
			addsub_res = sum[VALUE_W] ? VMIN : VMAX;
		end else begin
			addsub_res = sum[VALUE_W-1:0];
		end
	end

	always_comb begin
		if (nos == '0) begin
			dz_val = '0;
		end else begin
			dz_val = nos[VALUE_W-1] ? VMIN : VMAX;
		end
	end

	// one restoring step
	assign rem_sh = {rem_q, quo_q[QW-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tos_q <= digit_val;
		end else if (cmd.exec && (cmd.op == OP_ADD || cmd.op == OP_SUB)) begin
			tos_q <= addsub_res;
		end else if (cmd.exec && cmd.op == OP_DIV && tos_q == '0) begin
			tos_q <= dz_val;
		end else if (cmd.mul_wb) begin
			tos_q <= sat_mag(prod_q >> FRAC_BITS, neg_q);
		end else if (cmd.div_wb) begin
			tos_q <= sat_mag(64'(quo_q), neg_q);
		end

		if (cmd.exec) begin
			neg_q     <= nos[VALUE_W-1] ^ tos_q[VALUE_W-1];
			prod_q    <= 64'(mag(nos)) * 64'(mag(tos_q));
			quo_q     <= QW'(mag(nos)) << FRAC_BITS;
			dvs_q     <= mag(tos_q);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? VALUE_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[VALUE_W-1:0];
			quo_q     <= {quo_q[QW-2:0], ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end

		if (cmd.out_load) begin
			value_q  <= cmd.out_zero ? '0 : tos_q;
			status_q <= cmd.out_status;
		end
	end

	assign value  = value_q;
	assign status = status_q;

endmodule

### src/postfix_expression_evaluator_top.sv
// Top level of the postfix (RPN) expression evaluator over signed fixed point.
// Depends on pee_pkg, pee_ctrl, pee_dpath (which holds pee_ram).
//
//  channel  | signals                    | payload
//  ---------+----------------------------+--------------------------------------
//  input    | s_tvalid s_tready s_tdata  | tdata[7:0] symbol
//  result   | m_tvalid m_tready m_tdata  | tdata[31:0] value (Q16.16 default),
//           | m_tuser                    | tuser[2:0] status
//
// Skip symbols and digits are taken in the idle state; operators go through
// fetch, then a multiply write-back or the one-bit restoring divider. Results
// leave through a one-deep output register, so a new symbol is taken while a
// result waits; a symbol that makes a result stalls until that register is free.
// Reset empties the stack and drops any pending result; the stack RAM itself is
// not cleared.
module postfix_expression_evaluator_top
	import pee_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,   // 2..256 entries
	parameter int FRAC_BITS   = FRAC_BITS_DEF      // 0..24 fraction bits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] symbol
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] value
	output logic [2:0]  m_tuser     // [2:0] status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	status_t  status;

	// controller: symbol decode, operator sequencing, output valid
	pee_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.symbol  (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath: stack, arithmetic, result register
	pee_dpath #(
		.STACK_DEPTH(STACK_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.symbol(s_tdata),
		.cmd   (cmd),
		.stat  (stat),
		.value (m_tdata),
		.status(status)
	);

	assign m_tuser = status;

endmodule

### verif/postfix_expression_evaluator_tb.sv
// Self-checking testbench for postfix_expression_evaluator_top: directed and random
// postfix character streams, a scoreboard class that predicts every result.
// Depends on src/pee_pkg.sv and the evaluator RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pee_pkg::*;

	localparam int                 DEPTH     = STACK_DEPTH_DEF;
	localparam int                 FRAC      = FRAC_BITS_DEF;
	localparam int                 N_SYMBOLS = 1400;          // symbols to feed, blanks included
	localparam logic signed [31:0] VAL_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;

	typedef struct {
		logic signed [31:0] value;
		status_t            status;
	} eval_result_t;

	// Scoreboard: own copy of the operand stack, queue of results still owed by the DUT.
	class rpn_scoreboard;
		logic signed [31:0] operand_q [DEPTH];
		int unsigned        depth;
		eval_result_t       pending_results [$];
		int unsigned        mismatches;
		int unsigned        symbols_taken;
		int unsigned        results_checked;
		int unsigned        status_seen [5];

		function longint unsigned magnitude(logic signed [31:0] v);
			longint x;
			x = v;
			return (x < 0) ? -x : x;
		endfunction

		function logic signed [31:0] clamp(longint v);
			if (v > longint'(VAL_MAX))
				return VAL_MAX;
			if (v < longint'(VAL_MIN))
				return VAL_MIN;
			return v[31:0];
		endfunction

		function logic signed [31:0] apply_sign(longint unsigned m, bit neg);
			if (neg)
				return (m >= 64'h8000_0000) ? VAL_MIN : clamp(-longint'(m));
			return (m > 64'h7FFF_FFFF) ? VAL_MAX : clamp(longint'(m));
		endfunction

		// Advance the predicted stack by one accepted symbol; queue any result it makes.
		function void note_symbol(logic [7:0] sym);
			eval_result_t       res;
			logic signed [31:0] lhs, rhs, acc;
			bit                 emits, neg;

			symbols_taken++;
			emits      = 1'b1;
			res.value  = '0;
			res.status = STAT_OK;
			if (sym == CH_SPACE || sym == CH_TAB || sym == CH_COMMA)
				return;
			if (sym == CH_END) begin
				if (depth == 0)
					res.status = STAT_UNDER;
				else begin
					res.value = operand_q[depth-1];
					depth     = 0;
				end
			end else if (sym >= CH_ZERO && sym <= CH_NINE) begin
				if (depth >= DEPTH) begin
					depth      = 0;
					res.status = STAT_OVER;
				end else begin
					operand_q[depth] = {24'd0, sym - CH_ZERO} << FRAC;
					depth++;
					emits = 1'b0;
				end
			end else if (sym != CH_PLUS && sym != CH_MINUS && sym != CH_STAR && sym != CH_SLASH) begin
				depth      = 0;
				res.status = STAT_ILLEGAL;
			end else if (depth < 2) begin
				depth      = 0;
				res.status = STAT_UNDER;
			end else begin
				rhs   = operand_q[depth-1];
				lhs   = operand_q[depth-2];
				depth = depth - 2;
				neg   = lhs[31] != rhs[31];
				emits = 1'b0;
				case (sym)
					CH_PLUS:  acc = clamp(longint'(lhs) + longint'(rhs));
					CH_MINUS: acc = clamp(longint'(lhs) - longint'(rhs));
					CH_STAR:  acc = apply_sign((magnitude(lhs) * magnitude(rhs)) >> FRAC, neg);
					default: begin
						if (rhs == 0) begin
							// divide by zero saturates toward the dividend's sign
							acc        = (lhs > 0) ? VAL_MAX : ((lhs < 0) ? VAL_MIN : '0);
							emits      = 1'b1;
							res.status = STAT_DIVZERO;
						end else
							acc = apply_sign((magnitude(lhs) << FRAC) / magnitude(rhs), neg);
					end
				endcase
				operand_q[depth] = acc;
				depth++;
				res.value = acc;
			end
			if (emits)
				pending_results.push_back(res);
		endfunction

		function void check_result(logic [31:0] value, logic [2:0] status);
			eval_result_t want;

			results_checked++;
			if (status < 5)
				status_seen[status]++;
			if (pending_results.size() == 0) begin
				$error("result with no expectation: value %0d status %0d",
					$signed(value), status);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (value !== want.value) begin
				$error("value mismatch: expected %0d actual %0d", want.value, $signed(value));
				mismatches++;
			end
			if (status !== want.status) begin
				$error("status mismatch: expected %0d actual %0d", want.status, status);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;    // [7:0] symbol
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [31:0] value
	logic [2:0]  m_tuser;          // [2:0] status

	rpn_scoreboard rpn_check = new();
	int unsigned   fed_count = 0;  // non-blank symbols transferred

	postfix_expression_evaluator_top #(
		.STACK_DEPTH(DEPTH),
		.FRAC_BITS  (FRAC)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #2 clk = ~clk;

	// Offer one symbol after an optional idle gap; return once the transfer happens.
	// Valid stays high straight into the next symbol when no gap is drawn.
	task automatic send_symbol(input logic [7:0] sym, input bit burst);
		int gap;
		int roll;

		gap  = 0;
		roll = $urandom_range(0, 99);
		if (!burst) begin
			if (roll < 25)
				gap = $urandom_range(1, 3);
			else if (roll < 31)
				gap = $urandom_range(10, 40);  // occasional long gap
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		do
			@(posedge clk);
		while (!s_tready);
		rpn_check.note_symbol(sym);
		if (sym != CH_SPACE && sym != CH_TAB && sym != CH_COMMA)
			fed_count++;
	endtask

	task automatic send_text(input string text, input bit burst);
		for (int i = 0; i < text.len(); i++)
			send_symbol(text[i], burst);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_COMMA;
		endcase
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// One random expression, terminated by the end byte. Mostly well formed so the
	// arithmetic gets exercised; the rest is noise bytes and broken sequences.
	task automatic random_expression();
		logic [7:0] expr_q [$];
		int         kind, n_digits, pushed, level;
		bit         keep_extra, burst;

		kind  = $urandom_range(0, 99);
		burst = ($urandom_range(0, 3) == 0);
		if (kind < 80) begin
			// big trees now and then, to fill the stack near its depth
			n_digits   = ($urandom_range(0, 19) == 0) ? $urandom_range(12, DEPTH)
			                                          : $urandom_range(1, 7);
			keep_extra = ($urandom_range(0, 9) == 0);  // leave entries under the top
			pushed     = 0;
			level      = 0;
			forever begin
				if (pushed < n_digits && (level < 2 || $urandom_range(0, 2) != 0)) begin
					expr_q.push_back(pick_digit());
					pushed++;
					level++;
				end else if (level >= 2 && !(pushed == n_digits && keep_extra)) begin
					expr_q.push_back(pick_operator());
					level--;
				end else
					break;
			end
		end else if (kind < 90) begin
			// noise: any byte, legal or not
			repeat ($urandom_range(1, 4))
				expr_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					// operator starved of operands
					if ($urandom_range(0, 1))
						expr_q.push_back(pick_digit());
					expr_q.push_back(pick_operator());
				end
				1: begin
					// one digit past a full stack, rarely
					if ($urandom_range(0, 4) == 0)
						repeat (DEPTH + 1)
							expr_q.push_back(pick_digit());
				end
				2: begin
					// good start, then a stray byte mid-expression
					expr_q.push_back(pick_digit());
					expr_q.push_back(pick_digit());
					expr_q.push_back(8'($urandom_range(128, 255)));
					expr_q.push_back(pick_operator());
				end
				default: ;  // bare end byte on an empty stack
			endcase
		end
		foreach (expr_q[i]) begin
			send_symbol(expr_q[i], burst);
			if ($urandom_range(0, 99) < 15)
				send_symbol(pick_blank(), burst);
		end
		send_symbol(CH_END, burst);
	endtask

	// Result side: check every transfer, then pick m_tready for the next cycle.
	// Random stalls, quiet stretches with no stalls, and one long hold-off that
	// lets the output register fill and back up the input.
	initial begin
		int stall;
		int calm;
		bit held;
		int roll;

		stall = 0;
		calm  = 0;
		held  = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				rpn_check.check_result(m_tdata, m_tuser);
			if (!held && rpn_check.results_checked >= 80) begin
				held  = 1'b1;
				stall = 600;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 99) < 2)
					calm = $urandom_range(50, 300);
				roll = $urandom_range(0, 99);
				if (calm == 0 && roll < 25) begin
					stall    = (roll < 3) ? $urandom_range(10, 60) : $urandom_range(0, 2);
					m_tready <= 1'b0;
				end else
					m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: far above the slowest legal run (every symbol a divide, long gaps
	// and long receiver stalls throughout).
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: end and operator on an empty stack, an illegal byte
		send_symbol(CH_END, 1'b0);
		send_symbol(CH_PLUS, 1'b0);
		send_symbol(8'hFF, 1'b0);
		// positive divide by zero, then saturating multiply and add on top of it
		send_text("90/9*9+", 1'b0);
		send_symbol(CH_END, 1'b0);
		// negative divide by zero, saturating subtract, zero over zero, blanks,
		// a fractional quotient, and an end byte with several entries left
		send_text("09-0/9-00/ \t,72/", 1'b1);
		send_symbol(CH_END, 1'b0);
		// full stack, then one more digit
		repeat (DEPTH + 1)
			send_symbol(pick_digit(), 1'b1);
		send_symbol(CH_END, 1'b0);

		while (rpn_check.symbols_taken < N_SYMBOLS)
			random_expression();
		s_tvalid <= 1'b0;

		while (rpn_check.pending_results.size() != 0)
			@(posedge clk);
		// a trailing divide can keep the block busy after the last result
		repeat (100) @(posedge clk);

		$display("Fed %0d symbols (%0d non-blank), checked %0d results.",
			rpn_check.symbols_taken, fed_count, rpn_check.results_checked);
		$display("By status: ok %0d, illegal %0d, underflow %0d, overflow %0d, div-by-zero %0d.",
			rpn_check.status_seen[STAT_OK], rpn_check.status_seen[STAT_ILLEGAL],
			rpn_check.status_seen[STAT_UNDER], rpn_check.status_seen[STAT_OVER],
			rpn_check.status_seen[STAT_DIVZERO]);
		if (rpn_check.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
src/pee_pkg.sv
src/pee_ram.sv
src/pee_ctrl.sv
src/pee_dpath.sv
src/postfix_expression_evaluator_top.sv
verif/postfix_expression_evaluator_tb.sv
